FILE: rtl/bpls_pkg.sv
`default_nettype none
package bpls_pkg;

  // number formats
  localparam int FRAC_BITS      = 14;
  localparam int POW_TABLE_BITS = 8;
  localparam int LOG_FRAC       = 16;
  localparam int SHIN_FRAC      = 8;
  localparam int MANT_FRAC      = 30;

  // field widths
  localparam int COMP_W = 16;
  localparam int VEC_W  = 3 * COMP_W;
  localparam int SHIN_W = 16;
  localparam int CH_W   = 16;

  // pipeline depth, request to result
  localparam int NSTAGE = 8;

  // derived datapath widths
  localparam int PROD_C_W = 2 * COMP_W;
  localparam int DOT_W    = 2 * COMP_W + 2;
  localparam int X_W      = 2 * COMP_W + 1 - FRAC_BITS;
  localparam int E_W      = $clog2(X_W);
  localparam int LG_W     = 24;
  localparam int LGP_W    = LG_W + SHIN_W + 1;
  localparam int IP_W     = LGP_W - SHIN_FRAC - LOG_FRAC;
  localparam int MANT_W   = MANT_FRAC + 1;
  localparam int POW_W    = FRAC_BITS + 8;
  localparam int COL_W    = 2 * COMP_W;
  localparam int TERM_D_W = COL_W + X_W;
  localparam int TERM_S_W = COL_W + POW_W;
  localparam int ACC_W    = TERM_S_W + 2;
  localparam int OUT_SH   = 2 * FRAC_BITS + 2;
  localparam int TAB_N    = 1 << POW_TABLE_BITS;

  localparam logic [POW_W-1:0] POW_MAX = {POW_W{1'b1}};
  localparam logic [POW_W-1:0] POW_ONE = POW_W'(1) << FRAC_BITS;

  typedef logic [LOG_FRAC-1:0] log_tab_t [TAB_N];
  typedef logic [MANT_W-1:0]   exp_tab_t [TAB_N];

  // integer square root, one result bit per step
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bq;
    v   = v_in;
    res = '0;
    bq  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bq) begin
        v   = v - (res + bq);
        res = (res >> 1) + bq;
      end else begin
        res = res >> 1;
      end
      bq = bq >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/2^T) with LOG_FRAC fraction bits, by repeated squaring
  function automatic log_tab_t build_log_table();
    log_tab_t    t;
    logic [63:0] v;
    logic [LOG_FRAC-1:0] r;
    for (int i = 0; i < TAB_N; i++) begin
      v = (64'(TAB_N) + 64'(i)) << (MANT_FRAC - POW_TABLE_BITS);
      r = '0;
      for (int k = 1; k <= LOG_FRAC; k++) begin
        v = (v * v) >> MANT_FRAC;
        if (v >= (64'd1 << (MANT_FRAC + 1))) begin
          v = v >> 1;
          r[LOG_FRAC-k] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  // 2^(j/2^T) in Q1.30
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    t;
    logic [63:0] c;
    logic [63:0] m;
    for (int j = 0; j < TAB_N; j++) begin
      c = isqrt64(64'd1 << (2 * MANT_FRAC + 1));
      m = 64'd1 << MANT_FRAC;
      for (int k = 1; k <= POW_TABLE_BITS; k++) begin
        if (((j >> (POW_TABLE_BITS - k)) & 1) != 0) begin
          m = (m * c) >> MANT_FRAC;
        end
        c = isqrt64(c << MANT_FRAC);
      end
      t[j] = m[MANT_W-1:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TABLE = build_log_table();
  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

FILE: rtl/blinn_phong_light_shade.sv
// Blinn-Phong shading of one light, eight register stages.
// done is the last stage valid bit and rises together with the registered outputs.
// Throughput: one request per cycle; busy is held low and the pipeline never stalls.
// Each result is shown for one cycle with done; the receiver cannot stall.
// Reset clears the stage valid bits and done; datapath registers are not reset.
`default_nettype none
module blinn_phong_light_shade import bpls_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  input  wire logic [VEC_W-1:0]  lamp_dir,
  input  wire logic [VEC_W-1:0]  lamp_rgb,
  input  wire logic [VEC_W-1:0]  surface_normal,
  input  wire logic [VEC_W-1:0]  half_vector,
  input  wire logic [VEC_W-1:0]  diffuse_color,
  input  wire logic [VEC_W-1:0]  specular_color,
  input  wire logic [SHIN_W-1:0] shininess,
  output logic [CH_W-1:0]        red_out,
  output logic [CH_W-1:0]        green_out,
  output logic [CH_W-1:0]        blue_out,
  output logic                   clipped
);

  logic              take;
  logic [NSTAGE-1:0] vld;

  assign busy = 1'b0;
  assign take = start && !busy;

  // stage 1: component products of the two dot products
  logic signed [PROD_C_W-1:0] s1_nl [3];
  logic signed [PROD_C_W-1:0] s1_nh [3];
  logic [COMP_W-1:0]          s1_lc [3];
  logic [COMP_W-1:0]          s1_dc [3];
  logic [COMP_W-1:0]          s1_sc [3];
  logic [SHIN_W-1:0]          s1_shin;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_nl[k] <= $signed(surface_normal[COMP_W*k +: COMP_W])
                * $signed(lamp_dir[COMP_W*k +: COMP_W]);
      s1_nh[k] <= $signed(surface_normal[COMP_W*k +: COMP_W])
                * $signed(half_vector[COMP_W*k +: COMP_W]);
      s1_lc[k] <= lamp_rgb[COMP_W*k +: COMP_W];
      s1_dc[k] <= diffuse_color[COMP_W*k +: COMP_W];
      s1_sc[k] <= specular_color[COMP_W*k +: COMP_W];
    end
    s1_shin <= shininess;
  end

  // stage 2: sums, clamp and round; color products
  logic signed [DOT_W-1:0] sum_l, sum_h, rnd_l, rnd_h;
  logic [X_W-1:0]          d_c, x_c;
  logic [X_W-1:0]          s2_d, s2_x;
  logic [COL_W-1:0]        s2_dl [3];
  logic [COL_W-1:0]        s2_sl [3];
  logic [SHIN_W-1:0]       s2_shin;

  always_comb begin
    sum_l = DOT_W'(s1_nl[0]) + DOT_W'(s1_nl[1]) + DOT_W'(s1_nl[2]);
    sum_h = DOT_W'(s1_nh[0]) + DOT_W'(s1_nh[1]) + DOT_W'(s1_nh[2]);
    rnd_l = (sum_l + DOT_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    rnd_h = (sum_h + DOT_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    d_c   = (sum_l <= 0) ? '0 : rnd_l[X_W-1:0];
    x_c   = (sum_h <= 0) ? '0 : rnd_h[X_W-1:0];
  end

  always_ff @(posedge clk) begin
    s2_d <= d_c;
    s2_x <= x_c;
    for (int k = 0; k < 3; k++) begin
      s2_dl[k] <= s1_lc[k] * s1_dc[k];
      s2_sl[k] <= s1_lc[k] * s1_sc[k];
    end
    s2_shin <= s1_shin;
  end

  // stage 3: log2 of x from the leading one and the log table
  logic [E_W-1:0]                 e_c;
  logic [X_W+POW_TABLE_BITS-1:0]  xs_c;
  logic [POW_TABLE_BITS-1:0]      idx_c;
  int                             lg_i;
  logic signed [LG_W-1:0]         s3_lg;
  logic                           s3_s_zero, s3_x_zero;
  logic [X_W-1:0]                 s3_d;
  logic [COL_W-1:0]               s3_dl [3];
  logic [COL_W-1:0]               s3_sl [3];
  logic [SHIN_W-1:0]              s3_shin;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < X_W; i++) begin
      if (s2_x[i]) begin
        e_c = E_W'(i);
      end
    end
    xs_c  = {s2_x, {POW_TABLE_BITS{1'b0}}} >> e_c;
    idx_c = xs_c[POW_TABLE_BITS-1:0];
    lg_i  = (int'(e_c) - FRAC_BITS) * (1 << LOG_FRAC) + int'(LOG_TABLE[idx_c]);
  end

  always_ff @(posedge clk) begin
    s3_lg     <= LG_W'(lg_i);
    s3_s_zero <= (s2_shin == '0);
    s3_x_zero <= (s2_x == '0);
    s3_d      <= s2_d;
    s3_dl     <= s2_dl;
    s3_sl     <= s2_sl;
    s3_shin   <= s2_shin;
  end

  // stage 4: exponent times log
  logic signed [LGP_W-1:0] s4_prod;
  logic                    s4_s_zero, s4_x_zero;
  logic [X_W-1:0]          s4_d;
  logic [COL_W-1:0]        s4_dl [3];
  logic [COL_W-1:0]        s4_sl [3];

  always_ff @(posedge clk) begin
    s4_prod   <= $signed({1'b0, s3_shin}) * s3_lg;
    s4_s_zero <= s3_s_zero;
    s4_x_zero <= s3_x_zero;
    s4_d      <= s3_d;
    s4_dl     <= s3_dl;
    s4_sl     <= s3_sl;
  end

  // stage 5: split into integer and fraction, mantissa from the exp table
  logic signed [IP_W-1:0] s5_ip;
  logic [MANT_W-1:0]      s5_m;
  logic                   s5_s_zero, s5_x_zero;
  logic [X_W-1:0]         s5_d;
  logic [COL_W-1:0]       s5_dl [3];
  logic [COL_W-1:0]       s5_sl [3];

  always_ff @(posedge clk) begin
    s5_ip     <= s4_prod[LGP_W-1 -: IP_W];
    s5_m      <= EXP_TABLE[s4_prod[SHIN_FRAC+LOG_FRAC-1 -: POW_TABLE_BITS]];
    s5_s_zero <= s4_s_zero;
    s5_x_zero <= s4_x_zero;
    s5_d      <= s4_d;
    s5_dl     <= s4_dl;
    s5_sl     <= s4_sl;
  end

  // stage 6: scale the mantissa by 2^ip with rounding and saturation; a zero exponent gives one, a zero base zero
  int               ip_i, sh_i;
  logic [63:0]      wide_c;
  logic [POW_W-1:0] pw_c;
  logic [POW_W-1:0] s6_pw;
  logic [X_W-1:0]   s6_d;
  logic [COL_W-1:0] s6_dl [3];
  logic [COL_W-1:0] s6_sl [3];

  always_comb begin
    ip_i   = int'(s5_ip);
    sh_i   = MANT_FRAC - FRAC_BITS - ip_i;
    wide_c = '0;
    pw_c   = '0;
    priority if (s5_s_zero) begin
      pw_c = POW_ONE;
    end else if (s5_x_zero) begin
      pw_c = '0;
    end else if (ip_i >= MANT_FRAC - FRAC_BITS + 9) begin
      pw_c = POW_MAX;
    end else if (sh_i <= 0) begin
      wide_c = 64'(s5_m) << (-sh_i);
      pw_c   = (wide_c > 64'(POW_MAX)) ? POW_MAX : wide_c[POW_W-1:0];
    end else if (sh_i <= MANT_W) begin
      wide_c = (64'(s5_m) + (64'd1 << (sh_i - 1))) >> sh_i;
      pw_c   = (wide_c > 64'(POW_MAX)) ? POW_MAX : wide_c[POW_W-1:0];
    end else begin
      pw_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    s6_pw <= pw_c;
    s6_d  <= s5_d;
    s6_dl <= s5_dl;
    s6_sl <= s5_sl;
  end

  // stage 7: diffuse and specular terms per channel
  logic [TERM_D_W-1:0] s7_a [3];
  logic [TERM_S_W-1:0] s7_b [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s7_a[k] <= s6_dl[k] * s6_d;
      s7_b[k] <= s6_sl[k] * s6_pw;
    end
  end

  // stage 8: add, round, saturate
  logic [ACC_W-1:0] tot_c [3];
  logic [CH_W-1:0]  ch_c  [3];
  logic [2:0]       sat_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot_c[k] = (ACC_W'(s7_a[k]) + ACC_W'(s7_b[k])
                 + (ACC_W'(1) << (OUT_SH - 1))) >> OUT_SH;
      sat_c[k] = (tot_c[k] > ACC_W'({CH_W{1'b1}}));
      ch_c[k]  = sat_c[k] ? {CH_W{1'b1}} : tot_c[k][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    red_out   <= ch_c[0];
    green_out <= ch_c[1];
    blue_out  <= ch_c[2];
    clipped   <= |sat_c;
  end

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], take};
    end
  end

  assign done = vld[NSTAGE-1];

  // every request gives exactly one result, after passing through all NSTAGE valid bits
  a_req_gives_done: assert property (@(posedge clk) disable iff (rst)
    take |-> ##NSTAGE done) else $error("request lost in pipeline");

  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, NSTAGE)) else $error("result without request");

  a_clip_means_sat: assert property (@(posedge clk) disable iff (rst)
    (done && clipped) |-> (red_out == {CH_W{1'b1}} || green_out == {CH_W{1'b1}}
                           || blue_out == {CH_W{1'b1}}))
    else $error("clipped without saturated channel");

  a_zero_exp_pow_one: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && s5_s_zero) |=> (s6_pw == POW_ONE))
    else $error("zero exponent must give unit power");

endmodule
`default_nettype wire

FILE: bench/tb_blinn_phong_light_shade.sv
`timescale 1ns / 1ps
module tb_blinn_phong_light_shade import bpls_pkg::*; ();

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            clip;
  } shade_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              done;
  logic [VEC_W-1:0]  lamp_dir;
  logic [VEC_W-1:0]  lamp_rgb;
  logic [VEC_W-1:0]  surface_normal;
  logic [VEC_W-1:0]  half_vector;
  logic [VEC_W-1:0]  diffuse_color;
  logic [VEC_W-1:0]  specular_color;
  logic [SHIN_W-1:0] shininess;
  logic [CH_W-1:0]   red_out;
  logic [CH_W-1:0]   green_out;
  logic [CH_W-1:0]   blue_out;
  logic              clipped;

  shade_t      pending_shades[$];
  int          mismatch_count;
  logic [63:0] log_mant[TAB_N];
  logic [63:0] exp_mant[TAB_N];

  blinn_phong_light_shade dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .lamp_dir(lamp_dir), .lamp_rgb(lamp_rgb),
    .surface_normal(surface_normal), .half_vector(half_vector),
    .diffuse_color(diffuse_color), .specular_color(specular_color),
    .shininess(shininess), .red_out(red_out), .green_out(green_out),
    .blue_out(blue_out), .clipped(clipped)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // bitwise integer square root
  function automatic logic [63:0] root64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bq;
    v   = v_in;
    res = '0;
    bq  = 64'd1 << 62;
    while (bq > v) bq = bq >> 2;
    while (bq != 0) begin
      if (v >= res + bq) begin
        v   = v - (res + bq);
        res = (res >> 1) + bq;
      end else begin
        res = res >> 1;
      end
      bq = bq >> 2;
    end
    return res;
  endfunction

  // log2 and exp2 mantissa tables
  task automatic fill_mantissa_tables();
    logic [63:0] v;
    logic [63:0] c;
    logic [63:0] m;
    logic [63:0] r;
    for (int i = 0; i < TAB_N; i++) begin
      v = (64'(TAB_N) + 64'(i)) << (30 - POW_TABLE_BITS);
      r = '0;
      for (int k = 1; k <= 16; k++) begin
        v = (v * v) >> 30;
        if (v >= (64'd1 << 31)) begin
          v = v >> 1;
          r = r | (64'd1 << (16 - k));
        end
      end
      log_mant[i] = r;
      c = root64(64'd1 << 61);
      m = 64'd1 << 30;
      for (int k = 1; k <= POW_TABLE_BITS; k++) begin
        if (((i >> (POW_TABLE_BITS - k)) & 1) != 0) m = (m * c) >> 30;
        c = root64(c << 30);
      end
      exp_mant[i] = m;
    end
  endtask

  // dot product clamped at zero, rounded to FRAC_BITS fraction bits
  function automatic logic [63:0] dot_clamped(input logic [VEC_W-1:0] a,
                                              input logic [VEC_W-1:0] b);
    longint sum;
    sum = 0;
    for (int k = 0; k < 3; k++)
      sum += longint'($signed(a[16*k +: 16])) * longint'($signed(b[16*k +: 16]));
    if (sum <= 0) return 0;
    return (64'(sum) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  // x raised to s (Q8.8) via log2/exp2 tables
  function automatic logic [63:0] spec_power(input logic [63:0] x, input logic [15:0] s);
    int          e;
    int          sh;
    logic [63:0] idx;
    logic [63:0] m;
    longint      lg;
    longint      p;
    longint      ip;
    longint      fr;
    if (s == 0) return 64'd1 << FRAC_BITS;
    if (x == 0) return 0;
    e = 0;
    while ((x >> (e + 1)) != 0) e++;
    if (e >= POW_TABLE_BITS) idx = (x >> (e - POW_TABLE_BITS)) & (TAB_N - 1);
    else idx = (x << (POW_TABLE_BITS - e)) & (TAB_N - 1);
    lg = longint'(e - FRAC_BITS) * 65536 + longint'(log_mant[idx]);
    p  = (longint'(s) * lg) >>> 8;
    ip = p >>> 16;
    fr = p - ip * 65536;
    m  = exp_mant[fr >> (16 - POW_TABLE_BITS)];
    if (ip >= 30 - FRAC_BITS + 9) return 64'(POW_MAX);
    sh = 30 - FRAC_BITS - int'(ip);
    if (sh >= 63) return 0;
    if (sh <= 0) m = m << (-sh);
    else m = (m + (64'd1 << (sh - 1))) >> sh;
    return (m > 64'(POW_MAX)) ? 64'(POW_MAX) : m;
  endfunction

  // expected shaded color of the request on the ports
  function automatic shade_t shade_predict();
    shade_t      o;
    logic [63:0] d;
    logic [63:0] pw;
    logic [63:0] lc;
    logic [63:0] tot;
    logic [15:0] ch[3];
    d  = dot_clamped(surface_normal, lamp_dir);
    pw = spec_power(dot_clamped(surface_normal, half_vector), shininess);
    o.clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lc  = 64'(lamp_rgb[16*k +: 16]);
      tot = 64'(diffuse_color[16*k +: 16]) * lc * d
          + 64'(specular_color[16*k +: 16]) * lc * pw;
      tot = (tot + (64'd1 << (2 * FRAC_BITS + 1))) >> (2 * FRAC_BITS + 2);
      if (tot > 64'hFFFF) begin
        tot    = 64'hFFFF;
        o.clip = 1'b1;
      end
      ch[k] = tot[15:0];
    end
    o.red   = ch[0];
    o.green = ch[1];
    o.blue  = ch[2];
    return o;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at %0t: got %h expected %h", field, $time, got, want);
    mismatch_count++;
  endtask

  // check results, then record requests taken at this edge
  always @(posedge clk) begin
    shade_t want;
    if (!rst) begin
      if (done) begin
        if (pending_shades.size() == 0) begin
          $display("unexpected result at %0t", $time);
          mismatch_count++;
        end else begin
          want = pending_shades.pop_front();
          if (red_out !== want.red) report_mismatch("red_out", red_out, want.red);
          if (green_out !== want.green) report_mismatch("green_out", green_out, want.green);
          if (blue_out !== want.blue) report_mismatch("blue_out", blue_out, want.blue);
          if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
        end
      end
      if (start && !busy) pending_shades.push_back(shade_predict());
    end
  end

  // drive one request at the falling edge and wait until it is taken
  task automatic send_light(input logic [VEC_W-1:0] ld, input logic [VEC_W-1:0] lcol,
                            input logic [VEC_W-1:0] nrm, input logic [VEC_W-1:0] hv,
                            input logic [VEC_W-1:0] dif, input logic [VEC_W-1:0] spc,
                            input logic [SHIN_W-1:0] shin);
    lamp_dir       = ld;
    lamp_rgb       = lcol;
    surface_normal = nrm;
    half_vector    = hv;
    diffuse_color  = dif;
    specular_color = spc;
    shininess      = shin;
    start          = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [VEC_W-1:0] rand48();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // random vector, each component in +-1.0
  function automatic logic [VEC_W-1:0] rand_unitish();
    return vec3($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                $urandom_range(0, 32768) - 16384);
  endfunction

  task automatic test_directed();
    logic [VEC_W-1:0] up;
    logic [VEC_W-1:0] white;
    up    = vec3(0, 0, 16384);
    white = vec3(16384, 16384, 16384);
    // all zeros and all ones
    send_light('0, '0, '0, '0, '0, '0, '0);
    send_light('1, '1, '1, '1, '1, '1, '1);
    // zero exponent with zero base
    send_light(up, white, up, vec3(16384, 0, 0), white, white, 16'h0000);
    // zero base, positive exponent
    send_light(up, white, up, vec3(0, 16384, 0), white, white, 16'h1000);
    // head-on light, exponent one
    send_light(up, white, up, up, white, white, 16'h0100);
    // huge power
    send_light(up, white, vec3(32767, 32767, 32767), vec3(32767, 32767, 32767),
               white, vec3(1, 1, 1), 16'hFFFF);
    // tiny power
    send_light(up, white, up, vec3(0, 0, 1), white, white, 16'hFFFF);
    // negative dot products clamp
    send_light(vec3(0, 0, -16384), white, up, vec3(0, 0, -16384), white, white, 16'h2000);
    // channel overflow in one channel
    send_light(up, vec3(65535, 16384, 0), up, up, vec3(65535, 0, 0), white, 16'h0080);
    // most negative components
    send_light(vec3(-32768, -32768, -32768), '1, vec3(-32768, -32768, -32768),
               vec3(-32768, -32768, -32768), '1, '1, 16'h0001);
    // fractional shininess on an angled half vector
    send_light(up, white, up, vec3(8000, 0, 14000), white, white, 16'h1A80);
    send_light(vec3(11585, 0, 11585), white, up, vec3(0, 6000, 15000), white, white,
               16'h8000);
    idle_cycles(2);
  endtask

  // well-formed shading requests in bursts
  task automatic test_random_scenes(input int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < n; b++) begin
        send_light(rand_unitish(), rand48() & {3{16'h7FFF}}, rand_unitish(),
                   rand_unitish(), rand48() & {3{16'h3FFF}}, rand48() & {3{16'h3FFF}},
                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 16'h4000)));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  // raw bit patterns on every field
  task automatic test_random_raw(input int n);
    for (int i = 0; i < n; i++) begin
      send_light(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 16'($urandom));
      if ($urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 3));
    end
  endtask

  initial begin
    int waited;
    mismatch_count = 0;
    rst            = 1'b1;
    start          = 1'b0;
    lamp_dir       = '0;
    lamp_rgb       = '0;
    surface_normal = '0;
    half_vector    = '0;
    diffuse_color  = '0;
    specular_color = '0;
    shininess      = '0;
    fill_mantissa_tables();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_scenes(1400);
    test_random_raw(400);
    idle_cycles(1);
    waited = 0;
    while (pending_shades.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_shades.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bpls_pkg.sv
rtl/blinn_phong_light_shade.sv
bench/tb_blinn_phong_light_shade.sv
